// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset as disable
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// implication checked on every rising edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

// implication with the consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/rabm_pkg.sv =====
// ----------------------------------------------------------------------------
// rabm_pkg
// Shared constants, codes and types of the resizable array block mapper
// ----------------------------------------------------------------------------
package rabm_pkg;

    localparam int DEF_INDEX_BITS = 20;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_LOCATE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic       place;
        logic       write;
        logic       alloc;
        logic       free;
        logic [1:0] status;
    } flags_t;

endpackage

// ===== hw/rtl/rabm_index_map.sv =====
// ----------------------------------------------------------------------------
// rabm_index_map
// Maps an element index to its data block number and offset in the block
// ----------------------------------------------------------------------------
module rabm_index_map
    import rabm_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic [INDEX_BITS-1:0]         idx,
    output logic [INDEX_BITS/2+1:0]       blk,
    output logic [(INDEX_BITS+1)/2:0]     off
);

    localparam int R_W   = INDEX_BITS + 1;
    localparam int K_W   = $clog2(R_W);
    localparam int BLK_W = INDEX_BITS / 2 + 2;
    localparam int OFF_W = (INDEX_BITS + 1) / 2 + 1;

    logic [R_W-1:0] r;
    logic [K_W-1:0] k;
    logic [K_W-1:0] hi;
    logic [K_W-1:0] lo;
    logic [K_W:0]   k_inc;
    logic [R_W-1:0] b;
    logic [R_W-1:0] p;
    logic [R_W-1:0] sum;
    logic [R_W-1:0] mask;

    assign r = {1'b0, idx} + R_W'(1);

    // leading one of r
    always_comb
    begin
        k = '0;
        for (int i = 0; i < R_W; i++)
        begin
            if (r[i])
            begin
                k = K_W'(i);
            end
        end
    end

    assign k_inc = {1'b0, k} + (K_W+1)'(1);
    assign hi    = k_inc[K_W:1];
    assign lo    = k >> 1;

    assign b    = (r >> hi) - (R_W'(1) << lo);
    assign p    = (R_W'(1) << hi) + (R_W'(1) << lo) - R_W'(2);
    assign sum  = p + b;
    assign mask = (R_W'(1) << hi) - R_W'(1);

    assign blk = sum[BLK_W-1:0];
    assign off = mask[OFF_W-1:0] & r[OFF_W-1:0];

endmodule

// ===== hw/rtl/rabm_update.sv =====
// ----------------------------------------------------------------------------
// rabm_update
// Next values of the array bookkeeping counters for one command
// ----------------------------------------------------------------------------
module rabm_update
    import rabm_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic [1:0]                     command,
    input  logic [INDEX_BITS-1:0]          index,
    input  logic [INDEX_BITS:0]            count,
    input  logic [INDEX_BITS/2+1:0]        lbf,
    input  logic [INDEX_BITS/2+1:0]        sbf,
    input  logic [INDEX_BITS/2+1:0]        bc,
    input  logic [INDEX_BITS/2+1:0]        sbc,
    input  logic [INDEX_BITS/2+1:0]        lbn,
    input  logic [$clog2(INDEX_BITS+2)-1:0] sbn,
    input  logic [INDEX_BITS/2+1:0]        ab,
    output logic [INDEX_BITS:0]            count_next,
    output logic [INDEX_BITS/2+1:0]        lbf_next,
    output logic [INDEX_BITS/2+1:0]        sbf_next,
    output logic [INDEX_BITS/2+1:0]        bc_next,
    output logic [INDEX_BITS/2+1:0]        sbc_next,
    output logic [INDEX_BITS/2+1:0]        lbn_next,
    output logic [$clog2(INDEX_BITS+2)-1:0] sbn_next,
    output logic [INDEX_BITS/2+1:0]        ab_next,
    output logic [INDEX_BITS/2+1:0]        alloc_size,
    output logic [INDEX_BITS/2+1:0]        free_number,
    output flags_t                         flags
);

    localparam int CNT_W = INDEX_BITS + 1;
    localparam int BLK_W = INDEX_BITS / 2 + 2;
    localparam int SB_W  = $clog2(INDEX_BITS + 2);

    logic [BLK_W:0] lbn_plus2;

    assign lbn_plus2 = {1'b0, lbn} + (BLK_W+1)'(2);

    always_comb
    begin
        count_next  = count;
        lbf_next    = lbf;
        sbf_next    = sbf;
        bc_next     = bc;
        sbc_next    = sbc;
        lbn_next    = lbn;
        sbn_next    = sbn;
        ab_next     = ab;
        alloc_size  = '0;
        free_number = '0;
        flags       = '0;
        flags.status = ST_OK;

        unique case (command)
            CMD_PUSH:
            begin
                if (count[INDEX_BITS])
                begin
                    flags.status = ST_FULL;
                end
                else
                begin
                    if (lbf == bc)
                    begin
                        if (sbf == sbc)
                        begin
                            sbn_next = sbn + SB_W'(1);
                            if (sbn_next[0])
                            begin
                                bc_next = bc << 1;
                            end
                            else
                            begin
                                sbc_next = sbc << 1;
                            end
                            sbf_next = '0;
                        end
                        if (lbn_plus2 > {1'b0, ab})
                        begin
                            flags.alloc = 1'b1;
                            alloc_size  = bc_next;
                            ab_next     = ab + BLK_W'(1);
                        end
                        lbn_next = lbn + BLK_W'(1);
                        lbf_next = '0;
                        sbf_next = sbf_next + BLK_W'(1);
                    end
                    lbf_next    = lbf_next + BLK_W'(1);
                    count_next  = count + CNT_W'(1);
                    flags.write = 1'b1;
                    flags.place = 1'b1;
                end
            end
            CMD_POP:
            begin
                if (count == '0)
                begin
                    flags.status = ST_EMPTY;
                end
                else
                begin
                    count_next = count - CNT_W'(1);
                    lbf_next   = lbf - BLK_W'(1);
                    if (lbf_next == '0)
                    begin
                        if (lbn_plus2 == {1'b0, ab})
                        begin
                            flags.free  = 1'b1;
                            free_number = lbn + BLK_W'(1);
                            ab_next     = ab - BLK_W'(1);
                        end
                        if (count_next == '0)
                        begin
                            lbf_next = '0;
                            sbf_next = BLK_W'(1);
                            bc_next  = BLK_W'(1);
                            sbc_next = BLK_W'(1);
                            lbn_next = '0;
                            sbn_next = '0;
                            ab_next  = BLK_W'(1);
                        end
                        else
                        begin
                            lbn_next = lbn - BLK_W'(1);
                            sbf_next = sbf - BLK_W'(1);
                            if (sbf_next == '0)
                            begin
                                if (sbn[0])
                                begin
                                    bc_next = bc >> 1;
                                end
                                else
                                begin
                                    sbc_next = sbc >> 1;
                                end
                                sbn_next = sbn - SB_W'(1);
                                sbf_next = sbc_next;
                            end
                            lbf_next = bc_next;
                        end
                    end
                end
            end
            CMD_LOCATE:
            begin
                if ({1'b0, index} >= count)
                begin
                    flags.status = ST_RANGE;
                end
                else
                begin
                    flags.place = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/resizable_array_block_mapper.sv =====
// ----------------------------------------------------------------------------
// resizable_array_block_mapper
// Bookkeeping of a resizable array held in data blocks grouped in superblocks
// ----------------------------------------------------------------------------
// Takes one command word per clock cycle while cmd_stall is low (push, pop
// or locate) and returns one result word for each, in order. A word taken
// into the input register passes, once the result register is free, through
// the counter update and index mapping logic into the result register; the
// same edge updates the array counters. While a result is held by rsp_stall,
// one more command word is taken into the input register; then cmd_stall
// rises until the result moves on. Push reports where to store the value and
// whether a new block is needed, pop reports the spare block to free, and
// locate maps an index to block and offset. Full, empty and out of range are
// flagged in status and leave the counters unchanged.
module resizable_array_block_mapper
    import rabm_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [1:0]                    command,
    input  logic signed [31:0]            value,
    input  logic [INDEX_BITS-1:0]         index,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [INDEX_BITS:0]           element_count,
    output logic [INDEX_BITS/2+1:0]       block_number,
    output logic [(INDEX_BITS+1)/2:0]     block_offset,
    output logic                          write_enable,
    output logic signed [31:0]            write_data,
    output logic                          alloc_block,
    output logic [INDEX_BITS/2+1:0]       alloc_size,
    output logic                          free_block,
    output logic [INDEX_BITS/2+1:0]       free_block_number,
    output logic [1:0]                    status
);

    localparam int CNT_W = INDEX_BITS + 1;
    localparam int BLK_W = INDEX_BITS / 2 + 2;
    localparam int OFF_W = (INDEX_BITS + 1) / 2 + 1;
    localparam int SB_W  = $clog2(INDEX_BITS + 2);

    // input register
    logic                  in_valid_reg;
    logic [1:0]            command_reg;
    logic signed [31:0]    value_reg;
    logic [INDEX_BITS-1:0] index_reg;

    // array counters
    logic [CNT_W-1:0] count_reg, count_next;
    logic [BLK_W-1:0] lbf_reg, lbf_next;
    logic [BLK_W-1:0] sbf_reg, sbf_next;
    logic [BLK_W-1:0] bc_reg, bc_next;
    logic [BLK_W-1:0] sbc_reg, sbc_next;
    logic [BLK_W-1:0] lbn_reg, lbn_next;
    logic [SB_W-1:0]  sbn_reg, sbn_next;
    logic [BLK_W-1:0] ab_reg, ab_next;

    // result register
    logic                 rsp_valid_reg;
    logic [CNT_W-1:0]     element_count_reg;
    logic [BLK_W-1:0]     block_number_reg;
    logic [OFF_W-1:0]     block_offset_reg;
    logic                 write_enable_reg;
    logic signed [31:0]   write_data_reg;
    logic                 alloc_block_reg;
    logic [BLK_W-1:0]     alloc_size_reg;
    logic                 free_block_reg;
    logic [BLK_W-1:0]     free_block_number_reg;
    logic [1:0]           status_reg;

    logic                  advance;
    logic                  fire;
    logic                  take;
    logic [INDEX_BITS-1:0] map_idx;
    logic [BLK_W-1:0]      map_blk;
    logic [OFF_W-1:0]      map_off;
    logic [BLK_W-1:0]      upd_alloc_size;
    logic [BLK_W-1:0]      upd_free_number;
    flags_t                flags;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign fire      = in_valid_reg && advance;
    assign cmd_stall = in_valid_reg && !advance;
    assign take      = cmd_valid && !cmd_stall;

    assign map_idx = (command_reg == CMD_PUSH) ? count_reg[INDEX_BITS-1:0] : index_reg;

    rabm_index_map #(
        .INDEX_BITS (INDEX_BITS)
    ) u_map (
        .idx (map_idx),
        .blk (map_blk),
        .off (map_off)
    );

    rabm_update #(
        .INDEX_BITS (INDEX_BITS)
    ) u_upd (
        .command     (command_reg),
        .index       (index_reg),
        .count       (count_reg),
        .lbf         (lbf_reg),
        .sbf         (sbf_reg),
        .bc          (bc_reg),
        .sbc         (sbc_reg),
        .lbn         (lbn_reg),
        .sbn         (sbn_reg),
        .ab          (ab_reg),
        .count_next  (count_next),
        .lbf_next    (lbf_next),
        .sbf_next    (sbf_next),
        .bc_next     (bc_next),
        .sbc_next    (sbc_next),
        .lbn_next    (lbn_next),
        .sbn_next    (sbn_next),
        .ab_next     (ab_next),
        .alloc_size  (upd_alloc_size),
        .free_number (upd_free_number),
        .flags       (flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            lbf_reg       <= '0;
            sbf_reg       <= BLK_W'(1);
            bc_reg        <= BLK_W'(1);
            sbc_reg       <= BLK_W'(1);
            lbn_reg       <= '0;
            sbn_reg       <= '0;
            ab_reg        <= BLK_W'(1);
        end
        else
        begin
            if (!cmd_stall)
            begin
                in_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                count_reg <= count_next;
                lbf_reg   <= lbf_next;
                sbf_reg   <= sbf_next;
                bc_reg    <= bc_next;
                sbc_reg   <= sbc_next;
                lbn_reg   <= lbn_next;
                sbn_reg   <= sbn_next;
                ab_reg    <= ab_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            command_reg <= command;
            value_reg   <= value;
            index_reg   <= index;
        end
        if (fire)
        begin
            element_count_reg     <= count_next;
            block_number_reg      <= flags.place ? map_blk : '0;
            block_offset_reg      <= flags.place ? map_off : '0;
            write_enable_reg      <= flags.write;
            write_data_reg        <= flags.write ? value_reg : '0;
            alloc_block_reg       <= flags.alloc;
            alloc_size_reg        <= upd_alloc_size;
            free_block_reg        <= flags.free;
            free_block_number_reg <= upd_free_number;
            status_reg            <= flags.status;
        end
    end

    assign rsp_valid         = rsp_valid_reg;
    assign element_count     = element_count_reg;
    assign block_number      = block_number_reg;
    assign block_offset      = block_offset_reg;
    assign write_enable      = write_enable_reg;
    assign write_data        = write_data_reg;
    assign alloc_block       = alloc_block_reg;
    assign alloc_size        = alloc_size_reg;
    assign free_block        = free_block_reg;
    assign free_block_number = free_block_number_reg;
    assign status            = status_reg;

endmodule

// ===== hw/rtl/rabm_checker.sv =====
// ----------------------------------------------------------------------------
// rabm_checker
// Port-level checks of the resizable array block mapper, bound to the top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rabm_checker
    import rabm_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      rsp_valid,
    input logic                      rsp_stall,
    input logic [INDEX_BITS:0]       element_count,
    input logic                      write_enable,
    input logic                      alloc_block,
    input logic                      free_block,
    input logic [1:0]                status
);

    localparam logic [INDEX_BITS:0] MAX_COUNT = {1'b1, {INDEX_BITS{1'b0}}};

    // held word keeps its count
    `ASSERT_NEXT(a_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(element_count), "result word changed under stall")

    // a write only comes with a good status
    `ASSERT_IMPLY(a_write_ok, clk, rst_n, rsp_valid && write_enable, status == ST_OK, "write with error status")

    // allocation only on a push that writes
    `ASSERT_IMPLY(a_alloc_push, clk, rst_n, rsp_valid && alloc_block, write_enable && !free_block, "allocation without push")

    // freeing only on a good pop
    `ASSERT_IMPLY(a_free_pop, clk, rst_n, rsp_valid && free_block, !write_enable && status == ST_OK, "free without pop")

    // count never beyond capacity
    `ASSERT_IMPLY(a_count_max, clk, rst_n, rsp_valid, element_count <= MAX_COUNT, "element count too large")

endmodule

bind resizable_array_block_mapper rabm_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_rabm_checker (.*);

// ===== dv/resizable_array_block_mapper_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resizable_array_block_mapper_test
// Self-checking bench for the resizable array block mapper
// ----------------------------------------------------------------------------
// Sends push, pop and locate words through the command channel and checks
// every result word against a cycle-free model of the array counters kept
// in the bench. A short table covers reset behaviour, field extremes and the
// rejection codes, then a long random walk grows and shrinks the array, and
// a closing run of pushes goes at full rate. The sender works in bursts, the
// receiver stalls in its own pattern and once holds off long enough to back
// the block up.
// ----------------------------------------------------------------------------
module resizable_array_block_mapper_test;
    import rabm_pkg::*;

    localparam int IB = DEF_INDEX_BITS;
    localparam int BW = IB / 2 + 2;
    localparam int OW = (IB + 1) / 2 + 1;
    localparam int FULL_COUNT = 1 << IB;
    localparam int RANDOM_ITEMS = 1280;
    localparam int STEADY_PUSHES = 24;
    localparam int PRESSURE_HOLD = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [IB:0]    element_count;
        logic [BW-1:0]  block_number;
        logic [OW-1:0]  block_offset;
        logic           write_enable;
        logic [31:0]    write_data;
        logic           alloc_block;
        logic [BW-1:0]  alloc_size;
        logic           free_block;
        logic [BW-1:0]  free_block_number;
        logic [1:0]     status;
    } mapping_t;

    typedef struct packed {
        logic [1:0]     cmd;
        logic [31:0]    val;
        logic [IB-1:0]  idx;
        logic           typed;
        mapping_t       want;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    logic [1:0]         command = CMD_PUSH;
    logic signed [31:0] value = '0;
    logic [IB-1:0]      index = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [IB:0]        element_count;
    logic [BW-1:0]      block_number;
    logic [OW-1:0]      block_offset;
    logic               write_enable;
    logic signed [31:0] write_data;
    logic               alloc_block;
    logic [BW-1:0]      alloc_size;
    logic               free_block;
    logic [BW-1:0]      free_block_number;
    logic [1:0]         status;

    // array counters as the block should hold them
    logic [IB:0]        live_count;
    logic [BW-1:0]      tail_fill;
    logic [BW-1:0]      group_fill;
    logic [BW-1:0]      blk_size;
    logic [BW-1:0]      group_blocks;
    logic [BW-1:0]      tail_block;
    logic [4:0]         group_no;
    logic [BW-1:0]      blocks_held;

    mapping_t           pending_mappings[$];
    row_t               rows[$];
    int                 failures = 0;
    int                 checked = 0;
    int                 sent = 0;
    int                 burst_left = 0;
    int                 quiet = 0;
    bit                 steady = 1'b0;
    bit                 pressure_done = 1'b0;
    int                 deepest = 0;
    int                 allocs = 0;
    int                 frees = 0;
    int                 full_hits = 0;
    int                 empty_hits = 0;
    int                 range_hits = 0;

    resizable_array_block_mapper #(
        .INDEX_BITS        (IB)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (cmd_valid),
        .cmd_stall         (cmd_stall),
        .command           (command),
        .value             (value),
        .index             (index),
        .rsp_valid         (rsp_valid),
        .rsp_stall         (rsp_stall),
        .element_count     (element_count),
        .block_number      (block_number),
        .block_offset      (block_offset),
        .write_enable      (write_enable),
        .write_data        (write_data),
        .alloc_block       (alloc_block),
        .alloc_size        (alloc_size),
        .free_block        (free_block),
        .free_block_number (free_block_number),
        .status            (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_counters();
        live_count = '0;
        tail_fill = '0;
        group_fill = BW'(1);
        blk_size = BW'(1);
        group_blocks = BW'(1);
        tail_block = '0;
        group_no = '0;
        blocks_held = BW'(1);
    endfunction

    // index to block and offset via the leading one of index + 1
    function automatic void split_index(input logic [IB-1:0] idx, output logic [BW-1:0] b,
                                        output logic [OW-1:0] o);
        int r;
        int k;
        int hi;
        int lo;
        int blk;
        int off;
        r = int'(idx) + 1;
        k = 0;
        for (int j = 0; j <= IB; j++)
            if (r[j])
                k = j;
        hi = (k + 1) / 2;
        lo = k / 2;
        blk = (1 << hi) + (1 << lo) - 2 + (r >> hi) - (1 << lo);
        off = r & ((1 << hi) - 1);
        b = blk[BW-1:0];
        o = off[OW-1:0];
    endfunction

    function automatic mapping_t advance_array(input logic [1:0] c, input logic [31:0] v,
                                               input logic [IB-1:0] i);
        mapping_t m;
        logic [BW-1:0] b;
        logic [OW-1:0] o;
        m = '0;
        case (c)
            CMD_PUSH:
            begin
                if (int'(live_count) == FULL_COUNT)
                begin
                    m.status = ST_FULL;
                end
                else
                begin
                    if (tail_fill == blk_size)
                    begin
                        if (group_fill == group_blocks)
                        begin
                            group_no = group_no + 5'd1;
                            if (group_no[0])
                                blk_size = blk_size << 1;
                            else
                                group_blocks = group_blocks << 1;
                            group_fill = '0;
                        end
                        if (int'(tail_block) + 2 > int'(blocks_held))
                        begin
                            m.alloc_block = 1'b1;
                            m.alloc_size = blk_size;
                            blocks_held = blocks_held + BW'(1);
                        end
                        tail_block = tail_block + BW'(1);
                        tail_fill = '0;
                        group_fill = group_fill + BW'(1);
                    end
                    tail_fill = tail_fill + BW'(1);
                    live_count = live_count + (IB+1)'(1);
                    split_index(live_count[IB-1:0] - IB'(1), b, o);
                    m.block_number = b;
                    m.block_offset = o;
                    m.write_enable = 1'b1;
                    m.write_data = v;
                end
            end
            CMD_POP:
            begin
                if (live_count == '0)
                begin
                    m.status = ST_EMPTY;
                end
                else
                begin
                    live_count = live_count - (IB+1)'(1);
                    tail_fill = tail_fill - BW'(1);
                    if (tail_fill == '0)
                    begin
                        if (int'(tail_block) + 2 == int'(blocks_held))
                        begin
                            m.free_block = 1'b1;
                            m.free_block_number = tail_block + BW'(1);
                            blocks_held = blocks_held - BW'(1);
                        end
                        if (live_count == '0)
                        begin
                            clear_counters();
                        end
                        else
                        begin
                            tail_block = tail_block - BW'(1);
                            group_fill = group_fill - BW'(1);
                            // leaving a superblock halves what entering it doubled
                            if (group_fill == '0)
                            begin
                                if (group_no[0])
                                    blk_size = blk_size >> 1;
                                else
                                    group_blocks = group_blocks >> 1;
                                group_no = group_no - 5'd1;
                                group_fill = group_blocks;
                            end
                            tail_fill = blk_size;
                        end
                    end
                end
            end
            CMD_LOCATE:
            begin
                if ({1'b0, i} >= live_count)
                begin
                    m.status = ST_RANGE;
                end
                else
                begin
                    split_index(i, b, o);
                    m.block_number = b;
                    m.block_offset = o;
                end
            end
            default:
            begin
            end
        endcase
        m.element_count = live_count;
        return m;
    endfunction

    function automatic mapping_t spelled(input int cnt, input int blk, input int off,
                                         input logic we, input logic [31:0] wd,
                                         input logic [1:0] st);
        mapping_t m;
        m = '0;
        m.element_count = cnt[IB:0];
        m.block_number = blk[BW-1:0];
        m.block_offset = off[OW-1:0];
        m.write_enable = we;
        m.write_data = wd;
        m.status = st;
        return m;
    endfunction

    task automatic add_row(input logic [1:0] c, input logic [31:0] v, input logic [IB-1:0] i,
                           input logic typed, input mapping_t w);
        row_t r;
        r.cmd = c;
        r.val = v;
        r.idx = i;
        r.typed = typed;
        r.want = w;
        rows = {rows, r};
    endtask

    // called at a rising edge, returns at the edge that takes the word, or later after a gap between bursts
    task automatic offer(input logic [1:0] c, input logic [31:0] v, input logic [IB-1:0] i,
                         input logic typed, input mapping_t w);
        mapping_t m;
        bit taken;
        cmd_valid <= 1'b1;
        command <= c;
        value <= v;
        index <= i;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !cmd_stall;
            if (taken)
            begin
                m = advance_array(c, v, i);
                if (typed)
                    m = w;
                pending_mappings = {pending_mappings, m};
                sent++;
            end
            @(posedge clk);
        end
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                           : $urandom_range(1, 12);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("result %0d: %s got 0x%0h expected 0x%0h", checked, what, got, want);
        failures++;
    endtask

    task automatic check_mapping(input mapping_t got);
        mapping_t want;
        if (pending_mappings.size() == 0)
        begin
            note_mismatch("unexpected word, count", 32'(got.element_count), '0);
            return;
        end
        want = pending_mappings.pop_front();
        if (got.element_count !== want.element_count)
            note_mismatch("element_count", 32'(got.element_count), 32'(want.element_count));
        if (got.block_number !== want.block_number)
            note_mismatch("block_number", 32'(got.block_number), 32'(want.block_number));
        if (got.block_offset !== want.block_offset)
            note_mismatch("block_offset", 32'(got.block_offset), 32'(want.block_offset));
        if (got.write_enable !== want.write_enable)
            note_mismatch("write_enable", 32'(got.write_enable), 32'(want.write_enable));
        if (got.write_data !== want.write_data)
            note_mismatch("write_data", got.write_data, want.write_data);
        if (got.alloc_block !== want.alloc_block)
            note_mismatch("alloc_block", 32'(got.alloc_block), 32'(want.alloc_block));
        if (got.alloc_size !== want.alloc_size)
            note_mismatch("alloc_size", 32'(got.alloc_size), 32'(want.alloc_size));
        if (got.free_block !== want.free_block)
            note_mismatch("free_block", 32'(got.free_block), 32'(want.free_block));
        if (got.free_block_number !== want.free_block_number)
            note_mismatch("free_block_number", 32'(got.free_block_number),
                          32'(want.free_block_number));
        if (got.status !== want.status)
            note_mismatch("status", 32'(got.status), 32'(want.status));
    endtask

    // result side, sampled mid-cycle when everything is settled
    always @(negedge clk)
    begin
        mapping_t got;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            got.element_count = element_count;
            got.block_number = block_number;
            got.block_offset = block_offset;
            got.write_enable = write_enable;
            got.write_data = write_data;
            got.alloc_block = alloc_block;
            got.alloc_size = alloc_size;
            got.free_block = free_block;
            got.free_block_number = free_block_number;
            got.status = status;
            check_mapping(got);
            checked++;
            if (int'(element_count) > deepest)
                deepest = int'(element_count);
            if (alloc_block)
                allocs++;
            if (free_block)
                frees++;
            if (status == ST_FULL)
                full_hits++;
            if (status == ST_EMPTY)
                empty_hits++;
            if (status == ST_RANGE)
                range_hits++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
                if (quiet >= STALL_LIMIT)
                begin
                    $display("resizable_array_block_mapper verification failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin : receiver
        int run;
        bit choppy;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(10, 80);
            choppy = $urandom_range(0, 1);
            while (run > 0)
            begin
                @(posedge clk);
                if (!pressure_done && !steady && checked >= 300)
                begin
                    // long hold-off so the block backs up into cmd_stall
                    rsp_stall <= 1'b1;
                    repeat (PRESSURE_HOLD - 1) @(posedge clk);
                    pressure_done = 1'b1;
                end
                else
                begin
                    rsp_stall <= (choppy && !steady) ? ($urandom_range(0, 2) == 0) : 1'b0;
                end
                run--;
            end
        end
    end

    initial
    begin : stimulus
        int made;
        int seg_left;
        int roll;
        int pick;
        int raw_idx;
        bit growing;
        logic [1:0] c;
        logic [IB-1:0] i;

        clear_counters();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state, rejection codes and field extremes
        add_row(CMD_POP, '0, '0, 1'b1, spelled(0, 0, 0, 1'b0, '0, ST_EMPTY));
        add_row(CMD_LOCATE, '0, '0, 1'b1, spelled(0, 0, 0, 1'b0, '0, ST_RANGE));
        add_row(CMD_LOCATE, '1, '1, 1'b1, spelled(0, 0, 0, 1'b0, '0, ST_RANGE));
        add_row(CMD_UNUSED, '1, '1, 1'b1, spelled(0, 0, 0, 1'b0, '0, ST_OK));
        add_row(CMD_PUSH, 32'h8000_0000, '1, 1'b1,
                spelled(1, 0, 0, 1'b1, 32'h8000_0000, ST_OK));
        add_row(CMD_LOCATE, '0, '0, 1'b1, spelled(1, 0, 0, 1'b0, '0, ST_OK));
        add_row(CMD_LOCATE, '0, IB'(1), 1'b1, spelled(1, 0, 0, 1'b0, '0, ST_RANGE));
        add_row(CMD_PUSH, 32'h7FFF_FFFF, '0, 1'b0, '0);
        add_row(CMD_PUSH, 32'h0000_0000, '0, 1'b0, '0);
        add_row(CMD_PUSH, 32'hFFFF_FFFF, '0, 1'b0, '0);
        add_row(CMD_PUSH, 32'h5555_5555, '0, 1'b0, '0);
        add_row(CMD_PUSH, 32'hAAAA_AAAA, '0, 1'b0, '0);
        add_row(CMD_LOCATE, '0, IB'(5), 1'b0, '0);
        add_row(CMD_LOCATE, '0, IB'('hAAAAA), 1'b1, spelled(6, 0, 0, 1'b0, '0, ST_RANGE));
        add_row(CMD_LOCATE, '0, IB'('h55555), 1'b1, spelled(6, 0, 0, 1'b0, '0, ST_RANGE));
        repeat (6) add_row(CMD_POP, '1, '1, 1'b0, '0);
        add_row(CMD_POP, '0, '0, 1'b1, spelled(0, 0, 0, 1'b0, '0, ST_EMPTY));
        add_row(CMD_PUSH, 32'd1, '0, 1'b1, spelled(1, 0, 0, 1'b1, 32'd1, ST_OK));
        add_row(CMD_POP, '0, '0, 1'b1, spelled(0, 0, 0, 1'b0, '0, ST_OK));

        foreach (rows[n])
            offer(rows[n].cmd, rows[n].val, rows[n].idx, rows[n].typed, rows[n].want);

        // random walk in growing and shrinking stretches
        made = 0;
        seg_left = 0;
        growing = 1'b1;
        while (made < RANDOM_ITEMS)
        begin
            if (seg_left == 0)
            begin
                growing = ($urandom_range(0, 99) < 60);
                seg_left = $urandom_range(20, 150);
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                c = CMD_UNUSED;
            else if (roll < 23)
                c = CMD_LOCATE;
            else if (roll < (growing ? 83 : 38))
                c = CMD_PUSH;
            else
                c = CMD_POP;
            pick = $urandom_range(0, 99);
            if (pick < 70 && live_count != '0)
                raw_idx = $urandom_range(int'(live_count) - 1);
            else if (pick < 85)
                raw_idx = int'(live_count);
            else
                raw_idx = $urandom;
            i = raw_idx[IB-1:0];
            offer(c, $urandom, i, 1'b0, '0);
            if (c != CMD_UNUSED)
                made++;
        end

        // pushes at full rate, then a few mixed words
        steady = 1'b1;
        repeat (STEADY_PUSHES)
            offer(CMD_PUSH, $urandom, '0, 1'b0, '0);
        offer(CMD_PUSH, '1, '1, 1'b0, '0);
        offer(CMD_LOCATE, '0, '1, 1'b0, '0);
        offer(CMD_POP, '0, '0, 1'b0, '0);
        offer(CMD_LOCATE, '0, '1, 1'b0, '0);
        offer(CMD_PUSH, 32'h8000_0000, '0, 1'b0, '0);
        offer(CMD_PUSH, 32'h7FFF_FFFF, '0, 1'b0, '0);
        offer(CMD_LOCATE, '0, '0, 1'b0, '0);
        cmd_valid <= 1'b0;

        while (pending_mappings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d command words sent, %0d results checked, array grew to %0d elements",
                 sent, checked, deepest);
        $display("%0d block allocations, %0d frees; rejections: %0d full, %0d empty, %0d range",
                 allocs, frees, full_hits, empty_hits, range_hits);
        if (failures == 0)
            $display("resizable_array_block_mapper verification clean");
        else
            $display("resizable_array_block_mapper verification failed");
        $finish;
    end

endmodule
